FILE: rtl/d4wt_pkg.sv
// ============================================================================
// d4wt_pkg - shared types and constants for the D4 wavelet transform unit
// Sequencer states, register codes, default sizes and the Q1.15 tap table.
// ============================================================================
package d4wt_pkg;

    localparam int MAX_LEN_DEF   = 64;
    localparam int WORD_BITS_DEF = 24;
    localparam int IDX_W         = 6;
    localparam int COEF_W        = 16;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int LEN_LOG2_W    = 3;
    localparam int RND_SHIFT     = 15;

    // Q1.15 scaling filter taps
    localparam logic signed [COEF_W-1:0] COEF_H0 = 16'sd15826;
    localparam logic signed [COEF_W-1:0] COEF_H1 = 16'sd27411;
    localparam logic signed [COEF_W-1:0] COEF_H2 = 16'sd7345;
    localparam logic signed [COEF_W-1:0] COEF_H3 = -16'sd4240;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_LENGTH    = 1'b1;

    localparam logic [LEN_LOG2_W-1:0] LEN_LOG2_MIN   = 3'd2;
    localparam logic [LEN_LOG2_W-1:0] LEN_LOG2_MAX   = 3'd6;
    localparam logic [LEN_LOG2_W-1:0] LEN_LOG2_RESET = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_COPY,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // tap coefficient for direction, output parity and tap position
    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic       dir,
        input logic       sel,
        input logic [1:0] tap
    );
        logic signed [COEF_W-1:0] c;
        c = COEF_H0;
        case ({dir, sel, tap})
            4'b0000: c = COEF_H0;
            4'b0001: c = COEF_H1;
            4'b0010: c = COEF_H2;
            4'b0011: c = COEF_H3;
            4'b0100: c = COEF_H3;
            4'b0101: c = -COEF_H2;
            4'b0110: c = COEF_H1;
            4'b0111: c = -COEF_H0;
            4'b1000: c = COEF_H2;
            4'b1001: c = COEF_H1;
            4'b1010: c = COEF_H0;
            4'b1011: c = COEF_H3;
            4'b1100: c = COEF_H3;
            4'b1101: c = -COEF_H0;
            4'b1110: c = COEF_H1;
            4'b1111: c = -COEF_H2;
            default: c = COEF_H0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/daubechies_d4_wavelet_transform_unit.sv
// ============================================================================
// daubechies_d4_wavelet_transform_unit - multi-level periodic D4 transform
// Loads a block of signed Q16.8 words, transforms it in place with one
// shared multiply-accumulate and streams the result out with its index.
// ============================================================================
//
// Usage
//   Input: drive sample_in and pulse start; a word is taken at each rising
//   edge where start is high and busy is low. One transaction per cycle is
//   possible while loading. The word that completes the block (N = 2^length_log2,
//   capped at MAX_LEN) kicks off the transform and busy rises.
//   Transform: forward works on lengths N, N/2 .. 4, inverse on 4, 8 .. N.
//   Each level of length m issues 4 taps per output on a single multiplier,
//   drains the MAC pipe, copies scratch back and then chooses the next level.
//   The multiplier and the single read port of the block memory set the pace
//   of the compute.
//   Output: N result transactions on consecutive cycles, each marked by a
//   one-cycle strobe, with word_index 0..N-1 and last_word on index N-1.
//   The receiver cannot stall; busy stays high until the last strobe.
//   Config: APB writes at 0 (direction) and 4 (length_log2), only while
//   idle; any write drops a partly loaded block.
//   Reset: control state clears, direction forward, length_log2 = 6; the
//   data memories are not cleared and need no clearing pass.
//
module daubechies_d4_wavelet_transform_unit
    import d4wt_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] sample_in,
    output logic                        strobe,
    output logic signed [WORD_BITS-1:0] word_out,
    output logic [IDX_W-1:0]            word_index,
    output logic                        last_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready
);

    localparam int AW     = $clog2(MAX_LEN);        // memory address bits
    localparam int LW     = $clog2(MAX_LEN + 1);    // lengths up to MAX_LEN
    localparam int EW     = LW + 1;                 // room for 2*m and j+3
    localparam int PROD_W = WORD_BITS + COEF_W;
    localparam int ACC_W  = PROD_W + 2;             // four products summed
    localparam int RND_W  = ACC_W - RND_SHIFT;
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (RND_SHIFT - 1);
    localparam logic [LW-1:0] MIN_LEVEL = LW'(4);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic signed [WORD_BITS-1:0] block_mem   [MAX_LEN];
    logic signed [WORD_BITS-1:0] scratch_mem [MAX_LEN];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    state_t                  state_reg,    state_next;
    logic                    direction_reg, direction_next;
    logic [LEN_LOG2_W-1:0]   length_reg,   length_next;
    logic [LW-1:0]           load_cnt_reg, load_cnt_next;
    logic [LW-1:0]           m_reg,        m_next;        // current level length
    logic [AW-1:0]           pair_reg,     pair_next;
    logic                    sel_reg,      sel_next;      // which output of the pair
    logic [1:0]              tap_reg,      tap_next;
    logic [AW-1:0]           cnt_reg,      cnt_next;      // copy / emit index
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg;
    logic                    wr_pend_reg;
    logic                    cp_valid_reg, cp_valid_next;
    logic                    out_valid_reg, out_valid_next;

    // datapath registers (no reset)
    logic signed [COEF_W-1:0]    s1_coef_reg;
    logic                        s1_first_reg, s1_last_reg;
    logic [AW-1:0]               s1_dest_reg;
    logic signed [WORD_BITS-1:0] rd_reg;
    logic                        s2_first_reg, s2_last_reg;
    logic [AW-1:0]               s2_dest_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [AW-1:0]               wr_dest_reg;
    logic [AW-1:0]               cp_addr_reg;
    logic signed [WORD_BITS-1:0] scratch_rd_reg;
    logic [AW-1:0]               out_idx_reg, out_idx_next;
    logic                        out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Block length from the register: clip to 2..6, cap at MAX_LEN
    // ------------------------------------------------------------------
    logic [LEN_LOG2_W-1:0] lg_eff;
    logic [6:0]            n_pow;
    logic [LW-1:0]         n_len;

    assign lg_eff = (length_reg < LEN_LOG2_MIN) ? LEN_LOG2_MIN :
                    (length_reg > LEN_LOG2_MAX) ? LEN_LOG2_MAX : length_reg;
    assign n_pow  = 7'd1 << lg_eff;
    assign n_len  = (int'(n_pow) > MAX_LEN) ? LW'(MAX_LEN) : LW'(n_pow);

    // ------------------------------------------------------------------
    // Tap address and destination for the current issue slot
    // ------------------------------------------------------------------
    logic [LW-1:0] half;
    logic [EW-1:0] j_sum, m_ext;
    logic [LW-1:0] fwd_addr;
    logic [LW-1:0] inv_p, inv_base, inv_addr;
    logic [AW-1:0] tap_addr;
    logic [AW-1:0] tap_dest;
    logic          last_pair;

    assign half      = m_reg >> 1;
    assign last_pair = (LW'(pair_reg) + LW'(1)) == half;
    assign m_ext     = EW'(m_reg);
    assign j_sum     = EW'({pair_reg, 1'b0}) + EW'(tap_reg);
    assign fwd_addr  = (j_sum >= m_ext) ? LW'(j_sum - m_ext) : LW'(j_sum);
    // previous pair, wrapping around the half
    assign inv_p     = (pair_reg == '0) ? (half - LW'(1)) : (LW'(pair_reg) - LW'(1));
    assign inv_base  = tap_reg[1] ? LW'(pair_reg) : inv_p;
    assign inv_addr  = tap_reg[0] ? (inv_base + half) : inv_base;
    assign tap_addr  = (direction_reg == DIR_FWD) ? AW'(fwd_addr) : AW'(inv_addr);
    assign tap_dest  = (direction_reg == DIR_FWD) ?
                       (sel_reg ? AW'(LW'(pair_reg) + half) : pair_reg) :
                       AW'({pair_reg, sel_reg});

    // ------------------------------------------------------------------
    // Round to Q8 (ties up) and saturate to WORD_BITS
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]     rnd_sum;
    logic signed [RND_W-1:0]     rnd_val;
    logic                        rnd_ovf;
    logic signed [WORD_BITS-1:0] sat_word;

    assign rnd_sum  = acc_reg + RND_BIAS;
    assign rnd_val  = rnd_sum[ACC_W-1:RND_SHIFT];
    assign rnd_ovf  = !((&rnd_val[RND_W-1:WORD_BITS-1]) || !(|rnd_val[RND_W-1:WORD_BITS-1]));
    assign sat_word = !rnd_ovf ? rnd_val[WORD_BITS-1:0] :
                      rnd_val[RND_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} :
                                         {1'b0, {(WORD_BITS-1){1'b1}}};

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic accept;
    logic cfg_wr;

    assign busy   = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH) ? PDATA_W'(length_reg) : PDATA_W'(direction_reg);

    // block memory port selection
    logic                        blk_we;
    logic [AW-1:0]               blk_waddr;
    logic signed [WORD_BITS-1:0] blk_wdata;
    logic [AW-1:0]               blk_raddr;

    assign blk_we    = accept || cp_valid_reg;
    assign blk_waddr = accept ? AW'(load_cnt_reg) : cp_addr_reg;
    assign blk_wdata = accept ? sample_in : scratch_rd_reg;
    assign blk_raddr = (state_reg == ST_EMIT) ? cnt_reg : tap_addr;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [EW-1:0] m_dbl;
    logic [LW-1:0] m_half;

    assign m_dbl  = {m_reg, 1'b0};
    assign m_half = m_reg >> 1;

    always_comb
    begin
        state_next     = state_reg;
        direction_next = direction_reg;
        length_next    = length_reg;
        load_cnt_next  = load_cnt_reg;
        m_next         = m_reg;
        pair_next      = pair_reg;
        sel_next       = sel_reg;
        tap_next       = tap_reg;
        cnt_next       = cnt_reg;
        s1_valid_next  = 1'b0;
        cp_valid_next  = 1'b0;
        out_valid_next = 1'b0;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((load_cnt_reg + LW'(1)) >= n_len)
                    begin
                        load_cnt_next = '0;
                        m_next        = (direction_reg == DIR_FWD) ? n_len : MIN_LEVEL;
                        pair_next     = '0;
                        sel_next      = 1'b0;
                        tap_next      = '0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + LW'(1);
                    end
                end
            end
            ST_CALC:
            begin
                s1_valid_next = 1'b1;
                tap_next      = tap_reg + 2'd1;
                if (tap_reg == 2'd3)
                begin
                    sel_next = !sel_reg;
                    if (sel_reg)
                    begin
                        pair_next = pair_reg + AW'(1);
                        if (last_pair)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !wr_pend_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cp_valid_next = 1'b1;
                cnt_next      = cnt_reg + AW'(1);
                if ((LW'(cnt_reg) + LW'(1)) == m_reg)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                pair_next = '0;
                sel_next  = 1'b0;
                tap_next  = '0;
                cnt_next  = '0;
                if (direction_reg == DIR_FWD)
                begin
                    if (m_half >= MIN_LEVEL)
                    begin
                        m_next     = m_half;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    if (m_dbl <= EW'(n_len))
                    begin
                        m_next     = LW'(m_dbl);
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_idx_next   = cnt_reg;
                out_last_next  = (LW'(cnt_reg) + LW'(1)) == n_len;
                cnt_next       = cnt_reg + AW'(1);
                if ((LW'(cnt_reg) + LW'(1)) == n_len)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // any register write restarts loading
        if (cfg_wr)
        begin
            load_cnt_next = '0;
            if (paddr[2] == REG_DIRECTION)
            begin
                direction_next = pwdata[0];
            end
            else
            begin
                length_next = pwdata[LEN_LOG2_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            direction_reg <= DIR_FWD;
            length_reg    <= LEN_LOG2_RESET;
            load_cnt_reg  <= '0;
            m_reg         <= '0;
            pair_reg      <= '0;
            sel_reg       <= 1'b0;
            tap_reg       <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            cp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            direction_reg <= direction_next;
            length_reg    <= length_next;
            load_cnt_reg  <= load_cnt_next;
            m_reg         <= m_next;
            pair_reg      <= pair_next;
            sel_reg       <= sel_next;
            tap_reg       <= tap_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            wr_pend_reg   <= s2_valid_reg && s2_last_reg;
            cp_valid_reg  <= cp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // MAC pipe: issue -> read/coef -> multiply -> accumulate -> write
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_coef_reg  <= tap_coef(direction_reg, sel_reg, tap_reg);
        s1_first_reg <= (tap_reg == 2'd0);
        s1_last_reg  <= (tap_reg == 2'd3);
        s1_dest_reg  <= tap_dest;

        prod_reg     <= rd_reg * s1_coef_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_dest_reg  <= s1_dest_reg;

        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? ACC_W'(prod_reg) : (acc_reg + ACC_W'(prod_reg));
        end
        wr_dest_reg  <= s2_dest_reg;

        cp_addr_reg  <= cnt_reg;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    // block store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            block_mem[blk_waddr] <= blk_wdata;
        end
        rd_reg <= block_mem[blk_raddr];
    end

    // scratch store: level results in, copy-back reads out
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            scratch_mem[wr_dest_reg] <= sat_word;
        end
        scratch_rd_reg <= scratch_mem[cnt_reg];
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign strobe     = out_valid_reg;
    assign word_out   = rd_reg;
    assign word_index = IDX_W'(out_idx_reg);
    assign last_word  = out_valid_reg && out_last_reg;

endmodule

FILE: rtl/d4wt_checker.sv
// ============================================================================
// d4wt_checker - port-level checks for the D4 wavelet transform unit
// Checks how result transactions are sequenced against the busy flag.
// ============================================================================
module d4wt_checker
    import d4wt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input logic [IDX_W-1:0] word_index,
    input logic             last_word
);

    // results only while the unit is busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while not busy");

    // a block always starts at index zero
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> (word_index == '0))
        else $error("result block does not start at index 0");

    // results stream back to back with rising index
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_word) |=> (strobe && (word_index == ($past(word_index) + IDX_W'(1)))))
        else $error("result stream broken or index skipped");

    // nothing follows the last word of a block in the next cycle
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_word) |=> !strobe)
        else $error("result after last word");

    // the word that is taken never produces a result in the next cycle
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("result right after an accepted transaction");

endmodule

bind daubechies_d4_wavelet_transform_unit d4wt_checker u_d4wt_checker (.*);
